[src/tksd_pkg.sv]
// Shared types, constants and lookup functions for the terminal key sequence decoder.
// Used by tksd_front, tksd_back and the top level; depends on nothing.
`default_nettype none
package tksd_pkg;

  localparam int unsigned SeqMaxDefault    = 8;
  localparam int unsigned CoordBitsDefault = 12;
  localparam int unsigned NumW             = 16;  // widest mouse number carried in an item
  localparam int unsigned MatchBytes       = 4;   // longest CSI body that can match a key

  localparam logic [7:0] ChEsc   = 8'h1B;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChDel   = 8'h7F;
  localparam logic [7:0] ChC2    = 8'hC2;
  localparam logic [7:0] ChBrack = 8'h5B;
  localparam logic [7:0] ChLt    = 8'h3C;
  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [7:0] ChTilde = 8'h7E;

  localparam logic [4:0] KeyPlain = 5'd0;
  localparam logic [4:0] KeyEsc   = 5'd1;
  localparam logic [4:0] KeyBack  = 5'd6;
  localparam logic [4:0] KeyF1    = 5'd13;

  // modifier bits: [0] shift, [1] alt, [2] ctrl
  localparam logic [2:0] ModNone  = 3'b000;
  localparam logic [2:0] ModShift = 3'b001;
  localparam logic [2:0] ModAlt   = 3'b010;
  localparam logic [2:0] ModCtrl  = 3'b100;

  typedef enum logic [1:0] {
    KIND_KEY,
    KIND_CSI,
    KIND_MOUSE
  } kind_e;

  // item passed from front to back
  typedef struct packed {
    kind_e                       kind;
    logic [15:0]                 code;
    logic [4:0]                  named;
    logic [2:0]                  mods;
    logic                        tab;
    logic [MatchBytes-1:0][7:0]  seq;
    logic [2:0]                  seq_len;
    logic                        csi_ok;
    logic                        mouse_ok;
    logic [NumW-1:0]             num0;
    logic [NumW-1:0]             num1;
    logic [NumW-1:0]             num2;
  } rec_t;

  // result item
  typedef struct packed {
    logic [15:0]       key_code;
    logic [4:0]        named_key;
    logic              ctrl_flag;
    logic              alt_flag;
    logic              shift_flag;
    logic              tab_flag;
    logic              any_modifier;
    logic              is_mouse;
    logic [1:0]        mouse_button;
    logic signed [1:0] mouse_wheel;
    logic [11:0]       mouse_col;
    logic [11:0]       mouse_row;
  } res_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic [4:0] letter_key(input logic [7:0] c);
    logic [4:0] k;
    unique case (c)
      8'h41:   k = 5'd9;
      8'h42:   k = 5'd10;
      8'h43:   k = 5'd12;
      8'h44:   k = 5'd11;
      8'h46:   k = 5'd3;
      8'h48:   k = 5'd2;
      default: k = KeyPlain;
    endcase
    return k;
  endfunction

  function automatic logic [2:0] mod_bits(input logic [7:0] c);
    logic [2:0] m;
    unique case (c)
      8'h32:   m = 3'd1;
      8'h33:   m = 3'd2;
      8'h34:   m = 3'd3;
      8'h35:   m = 3'd4;
      8'h36:   m = 3'd5;
      default: m = ModNone;
    endcase
    return m;
  endfunction

  // vt tilde code number to named key
  function automatic logic [4:0] tilde_key(input logic [4:0] n);
    logic [4:0] k;
    unique case (n)
      5'd1, 5'd7: k = 5'd2;
      5'd2:       k = 5'd5;
      5'd3:       k = 5'd4;
      5'd4, 5'd8: k = 5'd3;
      5'd5:       k = 5'd7;
      5'd6:       k = 5'd8;
      5'd11:      k = 5'd13;
      5'd12:      k = 5'd14;
      5'd13:      k = 5'd15;
      5'd14:      k = 5'd16;
      5'd15:      k = 5'd17;
      5'd17:      k = 5'd18;
      5'd18:      k = 5'd19;
      5'd19:      k = 5'd20;
      5'd20:      k = 5'd21;
      5'd21:      k = 5'd22;
      5'd23:      k = 5'd23;
      5'd24:      k = 5'd24;
      default:    k = KeyPlain;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

[src/tksd_fifo.sv]
// Two-entry queue with push/full and pop/empty sides, used between the stages.
// Stand-alone; data width is a parameter.
`default_nettype none
module tksd_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o,
  output logic                  empty_o
);

  logic [WIDTH-1:0] slot_q [2];
  logic [1:0]       cnt_q, cnt_d;
  logic             wr_q, rd_q;
  logic             do_push, do_pop;

  assign full_o  = cnt_q[1];
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + 2'd1;
    else if (do_pop && !do_push) cnt_d = cnt_q - 2'd1;
  end

  // advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) wr_q <= !wr_q;
      if (do_pop)  rd_q <= !rd_q;
    end
  end

  // hold data
  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_q] <= data_i;
  end

endmodule
`default_nettype wire

[src/tksd_front.sv]
// Front stage: takes raw bytes, tracks escape/CSI/mouse parse state, emits classified items.
// Depends on tksd_pkg.
`default_nettype none
module tksd_front
  import tksd_pkg::*;
#(
  parameter int unsigned SEQ_MAX    = SeqMaxDefault,
  parameter int unsigned COORD_BITS = CoordBitsDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       take_i,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       more_pending_i,
  output logic            rec_valid_o,
  output rec_t            rec_o
);

  localparam int unsigned LenW = $clog2(SEQ_MAX + 1);
  localparam logic [LenW-1:0] LenMax = LenW'(SEQ_MAX);
  localparam logic [COORD_BITS-1:0] CoordMax = '1;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_ESC   = 3'd1;
  localparam logic [2:0] PH_CSI   = 3'd2;
  localparam logic [2:0] PH_MOUSE = 3'd3;
  localparam logic [2:0] PH_C2    = 3'd4;

  logic [2:0]                  ph_q, ph_d;
  logic [MatchBytes-1:0][7:0]  seq_q, seq_d;
  logic [LenW-1:0]             len_q, len_d;
  logic                        ovf_q, ovf_d;
  logic [COORD_BITS-1:0]       num_q [3];
  logic [COORD_BITS-1:0]       num_d [3];
  logic [1:0]                  idx_q, idx_d;
  logic [2:0]                  dseen_q, dseen_d;
  logic                        bad_q, bad_d;
  logic [COORD_BITS+3:0]       mac;
  logic [1:0]                  idx_sel;
  logic [7:0]                  c;
  logic                        term;

  assign c    = in_byte_i;
  assign term = is_letter(c) || (c == ChTilde);
  assign idx_sel = (idx_q > 2'd2) ? 2'd2 : idx_q;
  assign mac  = ({4'd0, num_q[idx_sel]} * (COORD_BITS+4)'(10))
              + (COORD_BITS+4)'(c[3:0]);

  // parse one byte
  always_comb begin
    ph_d        = ph_q;
    seq_d       = seq_q;
    len_d       = len_q;
    ovf_d       = ovf_q;
    num_d       = num_q;
    idx_d       = idx_q;
    dseen_d     = dseen_q;
    bad_d       = bad_q;
    rec_valid_o = 1'b0;
    rec_o       = '0;
    rec_o.kind  = KIND_KEY;
    unique case (ph_q)
      PH_ESC: begin
        if (c == ChEsc) begin
          ph_d = PH_ESC;
        end else if (is_letter(c)) begin
          ph_d = PH_IDLE;
          rec_valid_o = 1'b1;
          rec_o.code  = {8'd0, c};
          rec_o.mods  = ModAlt;
        end else if (c == ChBrack) begin
          ph_d  = PH_CSI;
          len_d = '0;
          ovf_d = 1'b0;
        end else begin
          ph_d = PH_IDLE;
          rec_valid_o = 1'b1;
          rec_o.code  = {8'd0, c};
          rec_o.named = (c == ChDel) ? KeyBack : KeyPlain;
        end
      end
      PH_CSI: begin
        if (len_q == '0 && c == ChLt) begin
          ph_d    = PH_MOUSE;
          num_d   = '{default: '0};
          idx_d   = 2'd0;
          dseen_d = 3'd0;
          bad_d   = 1'b0;
        end else begin
          if (len_q < LenMax) begin
            if (len_q < LenW'(MatchBytes)) seq_d[len_q[1:0]] = c;
            len_d = len_q + LenW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (term) begin
            ph_d = PH_IDLE;
            rec_valid_o   = 1'b1;
            rec_o.kind    = KIND_CSI;
            rec_o.seq     = seq_d;
            rec_o.seq_len = 3'(len_d);
            rec_o.csi_ok  = !ovf_d && (len_d <= LenW'(MatchBytes));
          end
        end
      end
      PH_MOUSE: begin
        if (term) begin
          ph_d = PH_IDLE;
          rec_valid_o    = 1'b1;
          rec_o.kind     = KIND_MOUSE;
          rec_o.mouse_ok = !bad_q && (idx_q == 2'd2) && dseen_q[2];
          rec_o.num0     = NumW'(num_q[0]);
          rec_o.num1     = NumW'(num_q[1]);
          rec_o.num2     = NumW'(num_q[2]);
        end else if (idx_q > 2'd2) begin
          bad_d = 1'b1;
        end else if (is_digit(c)) begin
          num_d[idx_sel]   = (mac > (COORD_BITS+4)'(CoordMax)) ? CoordMax
                                                               : mac[COORD_BITS-1:0];
          dseen_d[idx_sel] = 1'b1;
        end else if (c == ChSemi && idx_q < 2'd2 && dseen_q[idx_sel]) begin
          idx_d = idx_q + 2'd1;
        end else begin
          bad_d = 1'b1;
        end
      end
      PH_C2: begin
        ph_d = PH_IDLE;
        rec_valid_o = 1'b1;
        rec_o.code  = {ChC2, c};
      end
      default: begin
        ph_d = PH_IDLE;
        if (c == ChEsc) begin
          if (!more_pending_i) begin
            rec_valid_o = 1'b1;
            rec_o.code  = {8'd0, ChEsc};
            rec_o.named = KeyEsc;
          end else begin
            ph_d = PH_ESC;
          end
        end else if (c < ChEsc) begin
          rec_valid_o = 1'b1;
          if (c == ChTab) begin
            rec_o.code = 16'h0049;
            rec_o.tab  = 1'b1;
          end else begin
            rec_o.code = {8'd0, c + 8'd64};
            rec_o.mods = ModCtrl;
          end
        end else if (c == ChC2) begin
          ph_d = PH_C2;
        end else begin
          rec_valid_o = 1'b1;
          rec_o.code  = {8'd0, c};
          rec_o.named = (c == ChDel) ? KeyBack : KeyPlain;
        end
      end
    endcase
    if (!take_i) rec_valid_o = 1'b0;
  end

  // update parse state on an accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q    <= PH_IDLE;
      len_q   <= '0;
      ovf_q   <= 1'b0;
      num_q   <= '{default: '0};
      idx_q   <= 2'd0;
      dseen_q <= 3'd0;
      bad_q   <= 1'b0;
    end else if (take_i) begin
      ph_q    <= ph_d;
      len_q   <= len_d;
      ovf_q   <= ovf_d;
      num_q   <= num_d;
      idx_q   <= idx_d;
      dseen_q <= dseen_d;
      bad_q   <= bad_d;
    end
  end

  // hold collected sequence bytes
  always_ff @(posedge clk_i) begin
    if (take_i) seq_q <= seq_d;
  end

endmodule
`default_nettype wire

[src/tksd_back.sv]
// Back stage: matches CSI bodies to keys; formats mouse and key results.
// Purely combinational; depends on tksd_pkg.
`default_nettype none
module tksd_back
  import tksd_pkg::*;
(
  input  wire rec_t rec_i,
  output res_t      res_o
);

  logic [7:0] b0, b1, b2, fin;
  logic       ok;
  logic [4:0] named;
  logic [2:0] mods;
  logic       tab;
  logic [4:0] n2;

  assign b0  = rec_i.seq[0];
  assign b1  = rec_i.seq[1];
  assign b2  = rec_i.seq[2];
  assign fin = rec_i.seq[rec_i.seq_len[1:0] - 2'd1];
  assign n2  = ((b0 == 8'h31) ? 5'd10 : 5'd20) + {1'b0, b1[3:0]};

  // match the CSI body
  always_comb begin
    ok = 1'b0; named = KeyPlain; mods = ModNone; tab = 1'b0;
    if (rec_i.csi_ok) begin
      unique case (rec_i.seq_len)
        3'd1: begin
          if (fin == 8'h5A) begin
            ok = 1'b1; mods = ModShift; tab = 1'b1;
          end else begin
            named = letter_key(fin);
            ok = (named != KeyPlain);
          end
        end
        3'd2: begin
          if (b0 == 8'h31 && fin >= 8'h50 && fin <= 8'h53) begin
            ok = 1'b1; named = KeyF1 + {3'd0, fin[1:0]};
          end else if (fin == ChTilde && b0 >= 8'h31 && b0 <= 8'h38) begin
            ok = 1'b1; named = tilde_key({1'b0, b0[3:0]});
          end
        end
        3'd3: begin
          if (fin == ChTilde && (b0 == 8'h31 || b0 == 8'h32) && is_digit(b1)
              && n2 < 5'd25) begin
            named = tilde_key(n2);
            ok = (named != KeyPlain);
          end
        end
        3'd4: begin
          if (b1 == ChSemi && mod_bits(b2) != ModNone) begin
            if (fin == ChTilde) begin
              if (b0 == 8'h32 || b0 == 8'h33 || b0 == 8'h35 || b0 == 8'h36) begin
                ok = 1'b1; named = tilde_key({1'b0, b0[3:0]});
              end
            end else if (b0 == 8'h31) begin
              named = letter_key(fin);
              ok = (named != KeyPlain);
            end
            if (ok) mods = mod_bits(b2);
          end
        end
        default: ok = 1'b0;
      endcase
    end
  end

  // format the result item
  always_comb begin
    res_o = '0;
    unique case (rec_i.kind)
      KIND_CSI: begin
        if (ok) begin
          res_o.key_code   = {8'd0, ChBrack};
          res_o.named_key  = named;
          res_o.shift_flag = mods[0];
          res_o.alt_flag   = mods[1];
          res_o.ctrl_flag  = mods[2];
          res_o.tab_flag   = tab;
        end else begin
          res_o.key_code  = {8'd0, ChEsc};
          res_o.named_key = KeyEsc;
        end
      end
      KIND_MOUSE: begin
        res_o.key_code = {8'd0, ChBrack};
        res_o.is_mouse = 1'b1;
        if (rec_i.mouse_ok) begin
          if (rec_i.num0 == NumW'(0))  res_o.mouse_button = 2'd1;
          if (rec_i.num0 == NumW'(2))  res_o.mouse_button = 2'd2;
          if (rec_i.num0 == NumW'(65)) res_o.mouse_wheel  = 2'sd1;
          if (rec_i.num0 == NumW'(64)) res_o.mouse_wheel  = -2'sd1;
          res_o.mouse_col = rec_i.num1[11:0];
          res_o.mouse_row = rec_i.num2[11:0];
        end
      end
      default: begin
        res_o.key_code   = rec_i.code;
        res_o.named_key  = rec_i.named;
        res_o.shift_flag = rec_i.mods[0];
        res_o.alt_flag   = rec_i.mods[1];
        res_o.ctrl_flag  = rec_i.mods[2];
        res_o.tab_flag   = rec_i.tab;
      end
    endcase
    res_o.any_modifier = res_o.ctrl_flag | res_o.alt_flag | res_o.shift_flag;
  end

endmodule
`default_nettype wire

[src/terminal_key_sequence_decoder_top.sv]
// Top level of the terminal key sequence decoder: front parser, item queue, matcher, result queue.
// Depends on tksd_pkg, tksd_front, tksd_fifo and tksd_back.
`default_nettype none
// Turns a terminal byte stream into key and SGR mouse events. One byte is accepted per
// clock while full is low; a byte that ends a key gives one result, others give none.
// The item for a result is written into the item queue when its last byte is accepted,
// then passes the matcher into the result queue, whose head drives the ports. Both
// queues hold two items, so the block keeps taking one byte per cycle as long as
// results are popped at the rate they are made.
module terminal_key_sequence_decoder_top
  import tksd_pkg::*;
#(
  parameter int unsigned SEQ_MAX    = SeqMaxDefault,
  parameter int unsigned COORD_BITS = CoordBitsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  in_byte_i,
  input  wire logic        more_pending_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [15:0]      key_code_o,
  output logic [4:0]       named_key_o,
  output logic             ctrl_flag_o,
  output logic             alt_flag_o,
  output logic             shift_flag_o,
  output logic             tab_flag_o,
  output logic             any_modifier_o,
  output logic             is_mouse_o,
  output logic [1:0]       mouse_button_o,
  output logic signed [1:0] mouse_wheel_o,
  output logic [11:0]      mouse_col_o,
  output logic [11:0]      mouse_row_o
);

  logic rec_valid, rec_full, rec_empty, res_full;
  rec_t rec_in, rec_head;
  res_t res_in, res_head;

  assign full = rec_full;

  tksd_front #(.SEQ_MAX(SEQ_MAX), .COORD_BITS(COORD_BITS)) u_front (
    .clk_i, .rst_ni,
    .take_i        (push && !rec_full),
    .in_byte_i,
    .more_pending_i,
    .rec_valid_o   (rec_valid),
    .rec_o         (rec_in)
  );

  tksd_fifo #(.WIDTH($bits(rec_t))) u_rec_q (
    .clk_i, .rst_ni,
    .push_i  (rec_valid),
    .data_i  (rec_in),
    .full_o  (rec_full),
    .pop_i   (!res_full),
    .data_o  (rec_head),
    .empty_o (rec_empty)
  );

  tksd_back u_back (
    .rec_i (rec_head),
    .res_o (res_in)
  );

  tksd_fifo #(.WIDTH($bits(res_t))) u_res_q (
    .clk_i, .rst_ni,
    .push_i  (!rec_empty),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_head),
    .empty_o (empty)
  );

  // drive result ports
  assign key_code_o     = res_head.key_code;
  assign named_key_o    = res_head.named_key;
  assign ctrl_flag_o    = res_head.ctrl_flag;
  assign alt_flag_o     = res_head.alt_flag;
  assign shift_flag_o   = res_head.shift_flag;
  assign tab_flag_o     = res_head.tab_flag;
  assign any_modifier_o = res_head.any_modifier;
  assign is_mouse_o     = res_head.is_mouse;
  assign mouse_button_o = res_head.mouse_button;
  assign mouse_wheel_o  = res_head.mouse_wheel;
  assign mouse_col_o    = res_head.mouse_col;
  assign mouse_row_o    = res_head.mouse_row;

endmodule
`default_nettype wire
